// ===== src/md5_pkg.sv =====
package md5_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIN,
    ST_LEN,
    ST_COMP,
    ST_FOLD,
    ST_EMIT
  } state_t;

  // where the sequencer goes once a compression has been folded in
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_FIN,
    PH_LEN,
    PH_OUT
  } phase_t;

  localparam logic [31:0] H0_INIT = 32'h67452301;
  localparam logic [31:0] H1_INIT = 32'hefcdab89;
  localparam logic [31:0] H2_INIT = 32'h98badcfe;
  localparam logic [31:0] H3_INIT = 32'h10325476;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [5:0]  LEN_POS = 6'd56;

  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k;
    unique case (r)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amt(input logic [3:0] idx);
    logic [4:0] s;
    unique case (idx)
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
      default: s = 5'd7;
    endcase
    return s;
  endfunction

  // s is never zero here
  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
    return (x << s) | (x >> (6'd32 - {1'b0, s}));
  endfunction

endpackage

// ===== src/md5_in_if.sv =====
interface md5_in_if;
  import md5_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  logic       empty_message;

  modport source(output valid, data_byte, last_byte, empty_message, input ready);
  modport sink(input valid, data_byte, last_byte, empty_message, output ready);
endinterface

// ===== src/md5_out_if.sv =====
interface md5_out_if;
  import md5_pkg::*;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;

  modport source(output valid, digest_word, word_index, last_word, input ready);
  modport sink(input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== src/md5_digest.sv =====
// channel   dir  payload                                   handshake
// msg_in    in   data_byte[7:0] last_byte empty_message    valid/ready
// dig_out   out  digest_word[31:0] word_index[1:0] last_word valid/ready
//
// Bytes are taken while idle; every 64th byte starts a compression of
// 64 rounds plus a fold step, done by a single round unit. Message end
// costs a padding step and a compression, plus a length step and a
// second compression when the padding reaches past byte 55, then four
// output items.
// Reset (rst, synchronous) loads the initial chaining values and a zero count.
// msg_in is not ready while compressing or emitting; dig_out stalls hold the word.
module md5_digest
  import md5_pkg::*;
(
  input  logic clk,
  input  logic rst,
  md5_in_if.sink    msg_in,
  md5_out_if.source dig_out
);

  state_t state, state_next;
  phase_t phase;

  logic [31:0] chain [4];
  logic [31:0] msg [16];
  logic [60:0] byte_count;
  logic [5:0]  rnd;
  logic [1:0]  idx;
  logic [31:0] a, b, c, d;

  logic        in_acc, out_acc;
  logic [5:0]  pos;
  logic [3:0]  wi;
  logic [1:0]  lane;
  logic [63:0] bit_len;
  logic        blk_full;

  logic [31:0] f;
  logic [3:0]  g;
  logic [31:0] sum;

  assign in_acc  = msg_in.valid && msg_in.ready;
  assign out_acc = dig_out.valid && dig_out.ready;
  assign pos     = byte_count[5:0];
  assign wi      = pos[5:2];
  assign lane    = pos[1:0];
  assign bit_len = {byte_count, 3'b000};
  assign blk_full = (pos == 6'd63);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    msg_in.ready  = 1'b0;
    dig_out.valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        msg_in.ready = 1'b1;
        if (msg_in.valid) begin
          if (msg_in.empty_message) begin
            state_next = ST_FIN;
          end else if (blk_full) begin
            state_next = ST_COMP;
          end else if (msg_in.last_byte) begin
            state_next = ST_FIN;
          end
        end
      end
      ST_FIN:  state_next = ST_COMP;
      ST_LEN:  state_next = ST_COMP;
      ST_COMP: begin
        if (rnd == 6'd63) state_next = ST_FOLD;
      end
      ST_FOLD: begin
        unique case (phase)
          PH_IDLE: state_next = ST_IDLE;
          PH_FIN:  state_next = ST_FIN;
          PH_LEN:  state_next = ST_LEN;
          PH_OUT:  state_next = ST_EMIT;
          default: state_next = ST_IDLE;
        endcase
      end
      ST_EMIT: begin
        dig_out.valid = 1'b1;
        if (dig_out.ready && idx == 2'd3) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign dig_out.digest_word = chain[idx];
  assign dig_out.word_index  = idx;
  assign dig_out.last_word   = (idx == 2'd3);

  // round unit
  always_comb begin
    unique case (rnd[5:4])
      2'd0: begin
        f = (b & c) | (~b & d);
        g = rnd[3:0];
      end
      2'd1: begin
        f = (d & b) | (~d & c);
        g = 4'((rnd[3:0] * 4'd5) + 4'd1);
      end
      2'd2: begin
        f = b ^ c ^ d;
        g = 4'((rnd[3:0] * 4'd3) + 4'd5);
      end
      default: begin
        f = c ^ (b | ~d);
        g = 4'(rnd[3:0] * 4'd7);
      end
    endcase
    sum = f + a + round_k(rnd) + msg[g];
  end

  // control counters and chaining state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      rnd        <= '0;
      idx        <= '0;
      phase      <= PH_IDLE;
      chain[0]   <= H0_INIT;
      chain[1]   <= H1_INIT;
      chain[2]   <= H2_INIT;
      chain[3]   <= H3_INIT;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_acc && !msg_in.empty_message) begin
            byte_count <= byte_count + 61'd1;
            phase <= msg_in.last_byte ? PH_FIN : PH_IDLE;
          end
          rnd <= '0;
        end
        ST_FIN: begin
          phase <= (pos < LEN_POS) ? PH_OUT : PH_LEN;
          rnd <= '0;
        end
        ST_LEN: begin
          phase <= PH_OUT;
          rnd <= '0;
        end
        ST_COMP: rnd <= rnd + 6'd1;
        ST_FOLD: begin
          chain[0] <= chain[0] + a;
          chain[1] <= chain[1] + b;
          chain[2] <= chain[2] + c;
          chain[3] <= chain[3] + d;
          idx <= '0;
        end
        ST_EMIT: begin
          if (out_acc) begin
            idx <= idx + 2'd1;
            if (idx == 2'd3) begin
              chain[0]   <= H0_INIT;
              chain[1]   <= H1_INIT;
              chain[2]   <= H2_INIT;
              chain[3]   <= H3_INIT;
              byte_count <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // working variables
  always_ff @(posedge clk) begin
    if (state == ST_COMP) begin
      a <= d;
      d <= c;
      c <= b;
      b <= b + rotl32(sum, rot_amt({rnd[5:4], rnd[1:0]}));
    end else begin
      a <= chain[0];
      b <= chain[1];
      c <= chain[2];
      d <= chain[3];
    end
  end

  // message block
  always_ff @(posedge clk) begin
    for (int i = 0; i < 16; i++) begin
      if (state == ST_IDLE && in_acc && !msg_in.empty_message && 4'(i) == wi) begin
        for (int l = 0; l < 4; l++) begin
          if (2'(l) == lane) msg[i][8*l +: 8] <= msg_in.data_byte;
        end
      end else if (state == ST_FIN) begin
        if (4'(i) == wi) begin
          for (int l = 0; l < 4; l++) begin
            if (2'(l) == lane) begin
              msg[i][8*l +: 8] <= PAD_BYTE;
            end else if (2'(l) > lane) begin
              msg[i][8*l +: 8] <= 8'h00;
            end
          end
        end else if (4'(i) > wi) begin
          if (pos < LEN_POS && i == 14) begin
            msg[i] <= bit_len[31:0];
          end else if (pos < LEN_POS && i == 15) begin
            msg[i] <= bit_len[63:32];
          end else begin
            msg[i] <= '0;
          end
        end
      end else if (state == ST_LEN) begin
        if (i == 14) begin
          msg[i] <= bit_len[31:0];
        end else if (i == 15) begin
          msg[i] <= bit_len[63:32];
        end else begin
          msg[i] <= '0;
        end
      end
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(msg_in.ready && dig_out.valid))
    else $error("input taken while digest pending");

  a_fold_after_rounds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FOLD) |-> ($past(state) == ST_COMP && $past(rnd) == 6'd63))
    else $error("fold without 64 rounds");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    (out_acc && dig_out.last_word) |=> (byte_count == '0 && msg_in.ready))
    else $error("no restart after digest");

  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    (dig_out.valid && dig_out.last_word) |-> (dig_out.word_index == 2'd3))
    else $error("last word flag misplaced");

endmodule
